// ----- sv/utf8_char_scanner_unit_macros.svh -----
// ---------------------------------------------------------------------------
// utf8 char scanner assertion macros
// shared concurrent assertion forms, clocked on clock and quiet in reset
// ---------------------------------------------------------------------------
`ifndef UTF8_CHAR_SCANNER_UNIT_MACROS_SVH
`define UTF8_CHAR_SCANNER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define UCS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ucs assertion failed");

// next-cycle implication
`define UCS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ucs assertion failed");

`else

`define UCS_ASSERT_IMPL(lbl, ante, cons)
`define UCS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- sv/ucs_pkg.sv -----
// ---------------------------------------------------------------------------
// utf8 char scanner package
// types, byte codes and helpers shared by the scanner
// ---------------------------------------------------------------------------
package ucs_pkg;

   localparam logic [7:0] RUN_CAP    = 8'd255;
   localparam logic [7:0] LEAD_MIN   = 8'hC2;
   localparam logic [7:0] LEAD_3B    = 8'hE0;
   localparam logic [7:0] LEAD_4B    = 8'hF0;
   localparam logic [7:0] LEAD_F4    = 8'hF4;
   localparam logic [7:0] LEAD_END   = 8'hF5;
   localparam logic [7:0] E0_MIN     = 8'hA0;
   localparam logic [7:0] F0_LIMIT   = 8'h90;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DEL     = 8'd127;
   localparam logic [3:0] DIV_STEPS  = 4'd12;
   localparam logic [4:0] TAB_DEFAULT = 5'd8;

   typedef enum logic [0:0] {
      CSR_TAB_WIDTH = 1'b0,
      CSR_WIN_EOL   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_COLLECT = 2'd1,
      PH_RUN     = 2'd2,
      PH_CR      = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      SEQ_IDLE  = 2'd0,
      SEQ_DIV   = 2'd1,
      SEQ_SEND0 = 2'd2,
      SEQ_SEND1 = 2'd3
   } seq_type;

   typedef struct packed {
      logic [20:0] char_value;
      logic [7:0]  char_bytes;
      logic        valid_flag;
      logic        printable_flag;
      logic [4:0]  screen_width;
      logic        needs_width_lookup;
      logic        last_of_run;
   } result_type;

   function automatic result_type make_res(input logic [20:0] cp, input logic [7:0] len,
                                           input logic valid, input logic printable,
                                           input logic [4:0] width, input logic lookup);
      result_type r;
      r.char_value         = cp;
      r.char_bytes         = len;
      r.valid_flag         = valid;
      r.printable_flag     = printable;
      r.screen_width       = width;
      r.needs_width_lookup = lookup;
      r.last_of_run        = 1'b0;
      return r;
   endfunction

endpackage

// ----- sv/utf8_char_scanner_unit.sv -----
// ---------------------------------------------------------------------------
// utf8 char scanner unit
// decodes a utf-8 byte stream into one result per character with screen width
// ---------------------------------------------------------------------------
// One byte is taken per transfer when req_tready is high. A byte that closes
// no character leaves req_tready high for the next byte. A byte that gives
// results occupies the unit until each of its result transfers is taken (at most
// two results). A tab first runs a division: its width needs (column - 1) mod
// tab_width, which a shared restoring remainder unit works out one dividend bit
// per cycle over the 12-bit column. A carriage return in windows mode is held
// and reported with the following byte. No clearing pass is needed after reset.
`include "utf8_char_scanner_unit_macros.svh"

module utf8_char_scanner_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // text_byte[7:0], column[19:8], zero pad
   input  logic                  req_tlast,   // end_of_text
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // char_value[20:0], char_bytes[28:21], valid_flag[29], printable_flag[30],
   // screen_width[35:31], needs_width_lookup[36], zero pad
   output logic [39:0]           rsp_tdata,
   output logic                  rsp_tlast,   // last_of_run
   input  logic                  csr_we,
   input  ucs_pkg::csr_index_type csr_index,
   input  logic [4:0]            csr_wdata
);
   import ucs_pkg::*;

   // configuration
   logic [4:0]  tab_width_ff;
   logic        win_eol_ff;

   // scanner state
   phase_type   phase_ff, phase_in;
   logic [2:0]  exp_ff, exp_in;
   logic [7:0]  seen_ff, seen_in;
   logic [7:0]  lead_ff, lead_in;
   logic [20:0] acc_ff, acc_in;

   // sequencer and result slots
   seq_type     seq_ff, seq_in;
   result_type  slot0_ff, slot1_ff, res0, res1, cur_res;
   logic        two_ff, tab_at_ff;
   logic [1:0]  res_cnt;
   logic        tab_hit, tab_at;

   // shared remainder unit
   logic [4:0]  tw_ff;
   logic [4:0]  rem_ff, rem_in;
   logic [11:0] dvd_ff;
   logic [3:0]  cnt_ff;
   logic [5:0]  trial;
   logic [4:0]  tab_cols;
   logic        div_last;

   logic        req_xfer, rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff <= TAB_DEFAULT;
         win_eol_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TAB_WIDTH: tab_width_ff <= csr_wdata;
            CSR_WIN_EOL:   win_eol_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // byte scan: next decoder state and up to two results
   always_comb begin : scan
      logic [7:0]  b;
      logic        cont, do_scan, bad2, last_b;
      logic [20:0] acc_next;
      result_type  tail;
      b        = req_tdata[7:0];
      cont     = (b[7:6] == 2'b10);
      do_scan  = 1'b0;
      bad2     = 1'b0;
      last_b   = 1'b0;
      acc_next = {acc_ff[14:0], b[5:0]};
      tail     = make_res(21'd0, 8'd0, 1'b0, 1'b0, 5'd0, 1'b0);
      phase_in = phase_ff;
      exp_in   = exp_ff;
      seen_in  = seen_ff;
      lead_in  = lead_ff;
      acc_in   = acc_ff;
      res0     = make_res(21'd0, 8'd0, 1'b0, 1'b0, 5'd0, 1'b0);
      res1     = res0;
      res_cnt  = 2'd0;
      tab_hit  = 1'b0;
      tab_at   = 1'b0;

      case (phase_ff)
         PH_CR: begin
            last_b  = (b == CH_LF);
            res0    = make_res({13'd0, CH_CR}, 8'd1, 1'b1, last_b,
                               last_b ? 5'd0 : 5'd2, 1'b0);
            res_cnt = 2'd1;
            do_scan = 1'b1;
         end
         PH_RUN: begin
            if (cont) begin
               if (seen_ff < RUN_CAP) seen_in = seen_ff + 8'd1;
            end else begin
               res0    = make_res(21'd0, seen_ff, 1'b0, 1'b1, 5'd1, 1'b0);
               res_cnt = 2'd1;
               do_scan = 1'b1;
            end
         end
         PH_COLLECT: begin
            bad2 = (seen_ff == 8'd1) &&
                   ((lead_ff == LEAD_3B && b < E0_MIN) ||
                    (lead_ff == LEAD_4B && b < F0_LIMIT) ||
                    (lead_ff == LEAD_F4 && b >= F0_LIMIT));
            if (!cont) begin
               res0    = make_res(21'd0, seen_ff, 1'b0, 1'b1, 5'd1, 1'b0);
               res_cnt = 2'd1;
               do_scan = 1'b1;
            end else if (bad2) begin
               seen_in  = seen_ff + 8'd1;
               phase_in = PH_RUN;
            end else begin
               seen_in = seen_ff + 8'd1;
               if (seen_in >= {5'd0, exp_ff}) begin
                  res0     = make_res(acc_next, seen_in, 1'b1, 1'b1, 5'd0, 1'b1);
                  res_cnt  = 2'd1;
                  phase_in = PH_IDLE;
                  seen_in  = 8'd0;
                  exp_in   = 3'd0;
                  acc_in   = 21'd0;
               end else begin
                  acc_in = acc_next;
               end
            end
         end
         default: do_scan = 1'b1;
      endcase

      if (do_scan) begin
         phase_in = PH_IDLE;
         lead_in  = b;
         seen_in  = 8'd1;
         acc_in   = 21'd0;
         exp_in   = 3'd0;
         if (!b[7]) begin
            seen_in = 8'd0;
            if (b == CH_CR && win_eol_ff) begin
               phase_in = PH_CR;
            end else begin
               if (b == CH_LF)
                  tail = make_res({13'd0, b}, 8'd1, 1'b1, 1'b1, 5'd0, 1'b0);
               else if (b == CH_TAB)
                  tail = make_res({13'd0, b}, 8'd1, 1'b1, 1'b1, 5'd0, 1'b0);
               else if (b < CH_SPACE || b == CH_DEL)
                  tail = make_res({13'd0, b}, 8'd1, 1'b1, 1'b0, 5'd2, 1'b0);
               else
                  tail = make_res({13'd0, b}, 8'd1, 1'b1, 1'b1, 5'd1, 1'b0);
               tab_hit = (b == CH_TAB);
               tab_at  = res_cnt[0];
               if (res_cnt == 2'd0) res0 = tail;
               else res1 = tail;
               res_cnt = res_cnt + 2'd1;
            end
         end else if (b < LEAD_MIN || b >= LEAD_END) begin
            phase_in = PH_RUN;
         end else if (b < LEAD_3B) begin
            exp_in   = 3'd2;
            acc_in   = {16'd0, b[4:0]};
            phase_in = PH_COLLECT;
         end else if (b < LEAD_4B) begin
            exp_in   = 3'd3;
            acc_in   = {17'd0, b[3:0]};
            phase_in = PH_COLLECT;
         end else begin
            exp_in   = 3'd4;
            acc_in   = {18'd0, b[2:0]};
            phase_in = PH_COLLECT;
         end
      end

      // end of text flushes whatever is pending
      if (req_tlast && phase_in != PH_IDLE) begin
         if (phase_in == PH_CR)
            tail = make_res({13'd0, CH_CR}, 8'd1, 1'b1, 1'b0, 5'd2, 1'b0);
         else
            tail = make_res(21'd0, seen_in, 1'b0, 1'b1, 5'd1, 1'b0);
         if (res_cnt == 2'd0) res0 = tail;
         else res1 = tail;
         res_cnt  = res_cnt + 2'd1;
         phase_in = PH_IDLE;
         seen_in  = 8'd0;
         exp_in   = 3'd0;
         acc_in   = 21'd0;
      end

      if (res_cnt == 2'd1) res0.last_of_run = 1'b1;
      if (res_cnt == 2'd2) res1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         exp_ff   <= 3'd0;
         seen_ff  <= 8'd0;
         lead_ff  <= 8'd0;
         acc_ff   <= 21'd0;
      end else if (req_xfer) begin
         phase_ff <= phase_in;
         exp_ff   <= exp_in;
         seen_ff  <= seen_in;
         lead_ff  <= lead_in;
         acc_ff   <= acc_in;
      end
   end

   // restoring remainder step, one dividend bit per cycle
   assign trial    = {rem_ff, dvd_ff[11]};
   assign rem_in   = (trial >= {1'b0, tw_ff}) ? 5'(trial - {1'b0, tw_ff}) : trial[4:0];
   assign div_last = (cnt_ff == DIV_STEPS - 4'd1);
   assign tab_cols = tw_ff - rem_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else if (req_xfer) begin
         cnt_ff <= 4'd0;
      end else if (seq_ff == SEQ_DIV) begin
         cnt_ff <= cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         dvd_ff    <= req_tdata[19:8] - 12'd1;
         rem_ff    <= 5'd0;
         tw_ff     <= (tab_width_ff == 5'd0) ? 5'd1 : tab_width_ff;
         slot0_ff  <= res0;
         slot1_ff  <= res1;
         two_ff    <= (res_cnt == 2'd2);
         tab_at_ff <= tab_at;
      end else if (seq_ff == SEQ_DIV) begin
         dvd_ff <= {dvd_ff[10:0], 1'b0};
         rem_ff <= rem_in;
         if (div_last) begin
            if (tab_at_ff) slot1_ff.screen_width <= tab_cols;
            else slot0_ff.screen_width <= tab_cols;
         end
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) seq_ff <= SEQ_IDLE;
      else seq_ff <= seq_in;
   end

   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE: begin
            if (req_xfer && res_cnt != 2'd0) seq_in = tab_hit ? SEQ_DIV : SEQ_SEND0;
         end
         SEQ_DIV: begin
            if (div_last) seq_in = SEQ_SEND0;
         end
         SEQ_SEND0: begin
            if (rsp_tready) seq_in = two_ff ? SEQ_SEND1 : SEQ_IDLE;
         end
         SEQ_SEND1: begin
            if (rsp_tready) seq_in = SEQ_IDLE;
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cur_res    = slot0_ff;
      case (seq_ff)
         SEQ_IDLE:  req_tready = 1'b1;
         SEQ_DIV:   ;
         SEQ_SEND0: rsp_tvalid = 1'b1;
         SEQ_SEND1: begin
            rsp_tvalid = 1'b1;
            cur_res    = slot1_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tdata = {3'd0, cur_res.needs_width_lookup, cur_res.screen_width,
                       cur_res.printable_flag, cur_res.valid_flag, cur_res.char_bytes,
                       cur_res.char_value};
   assign rsp_tlast = cur_res.last_of_run;

   `UCS_ASSERT_IMPL(a_one_side, req_tready, !rsp_tvalid)
   `UCS_ASSERT_NEXT(a_second_follows, rsp_xfer && !rsp_tlast, rsp_tvalid && rsp_tlast)
   `UCS_ASSERT_IMPL(a_lookup_zero_width, rsp_tvalid && cur_res.needs_width_lookup,
                    cur_res.screen_width == 5'd0 && cur_res.valid_flag)
   `UCS_ASSERT_IMPL(a_div_bound, seq_ff == SEQ_DIV, cnt_ff < DIV_STEPS)

endmodule
